>>> sv/arpqm_pkg.sv
// Package for the attitude / rate PID quad-X mixer core.
// Holds the fixed-point widths, register indexes, reset values, mixer signs
// and the sequencer state type. No dependencies.
package arpqm_pkg;

  // Register file
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned RegW      = 16;

  localparam logic [RegIdxW-1:0] REG_ATT_P    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_RATE_P_X = 3'd1;
  localparam logic [RegIdxW-1:0] REG_RATE_I_X = 3'd4;
  localparam logic [RegIdxW-1:0] REG_TICK     = 3'd7;

  localparam logic [RegW-1:0] CFG_RESET [NumRegs] = '{
    16'd256, 16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'd66
  };

  // Datapath widths
  localparam int unsigned AngW   = 16;  // Q3.12 angles and rates
  localparam int unsigned ThrW   = 13;  // Q1.12 throttle and motors
  localparam int unsigned ErrW   = 17;  // exact angle difference
  localparam int unsigned RerrW  = 26;  // rate error
  localparam int unsigned IntW   = 32;  // integrator
  localparam int unsigned MulAW  = 32;
  localparam int unsigned MulBW  = 17;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned CmdW   = 42;
  localparam int unsigned MixW   = 44;

  localparam logic signed [ErrW-1:0] Q12_PI     = 17'sd12868;
  localparam logic signed [ErrW-1:0] Q12_TWO_PI = 17'sd25736;
  localparam logic [ThrW-1:0]        Q12_ONE    = 13'd4096;

  // Axis codes
  localparam logic [1:0] AXIS_ROLL  = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_YAW   = 2'd2;

  // Motor codes
  localparam logic [1:0] MOT_FR = 2'd0;
  localparam logic [1:0] MOT_RR = 2'd3;

  // Mixer signs per motor, one bit per axis (bit set: subtract that command)
  localparam logic [2:0] MIX_NEG [4] = '{
    3'b001,   // front right: -roll +pitch +yaw
    3'b100,   // front left:  +roll +pitch -yaw
    3'b010,   // rear left:   +roll -pitch +yaw
    3'b111    // rear right:  -roll -pitch -yaw
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_WRAP,
    ST_MUL_SP,
    ST_RERR,
    ST_MUL_DT,
    ST_INT,
    ST_MUL_P,
    ST_MUL_I,
    ST_CMD,
    ST_MIX,
    ST_DONE
  } state_e;

endpackage

>>> sv/attitude_rate_pid_quad_mixer_core.sv
// Attitude / rate PID controller with quad-X motor mixer, top level.
// One shared 32x17 multiplier under a small sequencer; uses arpqm_pkg.
//
// Usage: an armed tick runs the sequencer from input beat to result valid:
// eight sequencer steps per axis (four of them on the shared multiplier),
// one to four extra steps to wrap the yaw error, and twelve mixer steps, three
// additions for each of the four motors. A disarmed tick skips to the done
// state, gives all-zero motors and leaves the integrators alone. The block takes
// one tick at a time; a finished result sits in the output register while the
// next tick is accepted. Configuration writes are always ready and take
// effect at once; write them only while the block is idle.
module attitude_rate_pid_quad_mixer_core
  import arpqm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [RegW-1:0]           cfg_data_i,
  // input beat
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      armed_i,
  input  logic [ThrW-1:0]           throttle_i,
  input  logic signed [AngW-1:0]    target_roll_i,
  input  logic signed [AngW-1:0]    target_pitch_i,
  input  logic signed [AngW-1:0]    target_yaw_i,
  input  logic signed [AngW-1:0]    measured_roll_i,
  input  logic signed [AngW-1:0]    measured_pitch_i,
  input  logic signed [AngW-1:0]    measured_yaw_i,
  input  logic signed [AngW-1:0]    body_rate_x_i,
  input  logic signed [AngW-1:0]    body_rate_y_i,
  input  logic signed [AngW-1:0]    body_rate_z_i,
  // result beat
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ThrW-1:0]           motor_front_right_o,
  output logic [ThrW-1:0]           motor_front_left_o,
  output logic [ThrW-1:0]           motor_rear_left_o,
  output logic [ThrW-1:0]           motor_rear_right_o
);

  state_e state_q, state_d;

  logic [RegW-1:0]          cfg_q [NumRegs];
  logic signed [IntW-1:0]   integ_q [3];

  logic [ThrW-1:0]          thr_q;
  logic signed [AngW-1:0]   tgt_q [3];
  logic signed [AngW-1:0]   meas_q [3];
  logic signed [AngW-1:0]   rate_q [3];

  logic [1:0]               axis_q;
  logic [1:0]               mot_q;
  logic [1:0]               term_q;
  logic signed [ErrW-1:0]   err_q;
  logic signed [RerrW-1:0]  rerr_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ProdW-1:0]  acc_q;
  logic signed [CmdW-1:0]   cmd_q [3];
  logic signed [MixW-1:0]   mix_q;
  logic [ThrW-1:0]          motor_q [4];

  logic [ThrW-1:0]          out_q [4];
  logic                     out_valid_q;

  logic in_fire, load_out, wrap_done, axis_last;

  // Config writes are never stalled
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) begin
        cfg_q[r] <= CFG_RESET[r];
      end
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      cfg_q[cfg_index_i[RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  // Shared multiplier: operand select per step
  logic signed [MulAW-1:0] mul_a;
  logic [RegW-1:0]         mul_g;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  always_comb begin
    mul_a = MulAW'(err_q);
    mul_g = cfg_q[REG_ATT_P];
    case (state_q)
      ST_MUL_DT: begin
        mul_a = MulAW'(rerr_q);
        mul_g = cfg_q[REG_TICK];
      end
      ST_MUL_P: begin
        mul_a = MulAW'(rerr_q);
        mul_g = cfg_q[REG_RATE_P_X + RegIdxW'(axis_q)];
      end
      ST_MUL_I: begin
        mul_a = integ_q[axis_q];
        mul_g = cfg_q[REG_RATE_I_X + RegIdxW'(axis_q)];
      end
      default: begin
        mul_a = MulAW'(err_q);
        mul_g = cfg_q[REG_ATT_P];
      end
    endcase
  end

  assign mul_b = $signed({1'b0, mul_g});
  assign mul_p = mul_a * mul_b;

  // Rate setpoint (round half up) minus measured rate
  logic signed [ProdW-1:0]  sp_rnd;
  logic signed [RerrW-1:0]  rerr_d;
  assign sp_rnd = (prod_q + ProdW'(128)) >>> 8;
  assign rerr_d = RerrW'(sp_rnd) - RerrW'(rate_q[axis_q]);

  // Integrator step with saturation
  logic signed [ProdW-1:0]  dt_rnd;
  logic signed [IntW:0]     integ_sum;
  logic signed [IntW-1:0]   integ_d;
  assign dt_rnd    = (prod_q + ProdW'(32768)) >>> 16;
  assign integ_sum = (IntW+1)'(integ_q[axis_q]) + (IntW+1)'($signed(dt_rnd[RerrW-1:0]));
  always_comb begin
    if (integ_sum[IntW] != integ_sum[IntW-1]) begin
      integ_d = integ_sum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end else begin
      integ_d = integ_sum[IntW-1:0];
    end
  end

  // Axis command: P and I products summed wide, then rounded
  logic signed [ProdW:0]    cmd_sum;
  logic signed [ProdW:0]    cmd_rnd;
  assign cmd_sum = (ProdW+1)'(acc_q) + (ProdW+1)'(prod_q) + (ProdW+1)'(128);
  assign cmd_rnd = cmd_sum >>> 8;

  // Mixer: one signed term per cycle, clamp on the last
  logic signed [MixW-1:0]   mix_base;
  logic signed [MixW-1:0]   mix_term;
  logic signed [MixW-1:0]   mix_sum;
  logic [ThrW-1:0]          mix_clamp;
  logic                     mix_neg;
  assign mix_base = (term_q == AXIS_ROLL) ? $signed(MixW'(thr_q)) : mix_q;
  assign mix_term = MixW'(cmd_q[term_q]);
  assign mix_neg  = MIX_NEG[mot_q][term_q];
  assign mix_sum  = mix_neg ? (mix_base - mix_term) : (mix_base + mix_term);
  always_comb begin
    if (mix_sum < 0) begin
      mix_clamp = '0;
    end else if (mix_sum > $signed(MixW'(Q12_ONE))) begin
      mix_clamp = Q12_ONE;
    end else begin
      mix_clamp = mix_sum[ThrW-1:0];
    end
  end

  assign wrap_done = (err_q <= Q12_PI) && (err_q >= -Q12_PI);
  assign axis_last = (axis_q == AXIS_YAW);

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake controls
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = armed_i ? ST_ERR : ST_DONE;
        end
      end
      ST_ERR:    state_d = axis_last ? ST_WRAP : ST_MUL_SP;
      ST_WRAP:   state_d = wrap_done ? ST_MUL_SP : ST_WRAP;
      ST_MUL_SP: state_d = ST_RERR;
      ST_RERR:   state_d = ST_MUL_DT;
      ST_MUL_DT: state_d = ST_INT;
      ST_INT:    state_d = ST_MUL_P;
      ST_MUL_P:  state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_CMD;
      ST_CMD:    state_d = axis_last ? ST_MIX : ST_ERR;
      ST_MIX: begin
        if ((term_q == AXIS_YAW) && (mot_q == MOT_RR)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Integrators: reset to zero, update once per armed tick per axis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        integ_q[a] <= '0;
      end
    end else if (state_q == ST_INT) begin
      integ_q[axis_q] <= integ_d;
    end
  end

  // Sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_ROLL;
      mot_q  <= MOT_FR;
      term_q <= AXIS_ROLL;
    end else begin
      if (in_fire) begin
        axis_q <= AXIS_ROLL;
        mot_q  <= MOT_FR;
        term_q <= AXIS_ROLL;
      end else if ((state_q == ST_CMD) && !axis_last) begin
        axis_q <= axis_q + 2'd1;
      end else if (state_q == ST_MIX) begin
        if (term_q == AXIS_YAW) begin
          term_q <= AXIS_ROLL;
          mot_q  <= mot_q + 2'd1;
        end else begin
          term_q <= term_q + 2'd1;
        end
      end
    end
  end

  // Datapath registers: capture the beat, then advance one step per cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      thr_q     <= throttle_i;
      tgt_q[0]  <= target_roll_i;
      tgt_q[1]  <= target_pitch_i;
      tgt_q[2]  <= target_yaw_i;
      meas_q[0] <= measured_roll_i;
      meas_q[1] <= measured_pitch_i;
      meas_q[2] <= measured_yaw_i;
      rate_q[0] <= body_rate_x_i;
      rate_q[1] <= body_rate_y_i;
      rate_q[2] <= body_rate_z_i;
      for (int m = 0; m < 4; m++) begin
        motor_q[m] <= '0;
      end
    end
    case (state_q)
      ST_ERR:    err_q <= ErrW'(tgt_q[axis_q]) - ErrW'(meas_q[axis_q]);
      ST_WRAP: begin
        if (err_q > Q12_PI) begin
          err_q <= err_q - Q12_TWO_PI;
        end else if (err_q < -Q12_PI) begin
          err_q <= err_q + Q12_TWO_PI;
        end
      end
      ST_MUL_SP: prod_q <= mul_p;
      ST_RERR:   rerr_q <= rerr_d;
      ST_MUL_DT: prod_q <= mul_p;
      ST_MUL_P:  prod_q <= mul_p;
      ST_MUL_I: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_CMD:    cmd_q[axis_q] <= cmd_rnd[CmdW-1:0];
      ST_MIX: begin
        mix_q <= mix_sum;
        if (term_q == AXIS_YAW) begin
          motor_q[mot_q] <= mix_clamp;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      for (int m = 0; m < 4; m++) begin
        out_q[m] <= motor_q[m];
      end
    end
  end

  // Output register: hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign motor_front_right_o = out_q[0];
  assign motor_front_left_o  = out_q[1];
  assign motor_rear_left_o   = out_q[2];
  assign motor_rear_right_o  = out_q[3];

endmodule

>>> sv/arpqm_checker.sv
// Port-level checker for the attitude / rate PID quad-X mixer core.
// Uses arpqm_pkg; bound to attitude_rate_pid_quad_mixer_core below.
module arpqm_checker
  import arpqm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CfgIdxW-1:0]     cfg_index_i,
  input logic [RegW-1:0]        cfg_data_i,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   armed_i,
  input logic [ThrW-1:0]        throttle_i,
  input logic signed [AngW-1:0] target_roll_i,
  input logic signed [AngW-1:0] target_pitch_i,
  input logic signed [AngW-1:0] target_yaw_i,
  input logic signed [AngW-1:0] measured_roll_i,
  input logic signed [AngW-1:0] measured_pitch_i,
  input logic signed [AngW-1:0] measured_yaw_i,
  input logic signed [AngW-1:0] body_rate_x_i,
  input logic signed [AngW-1:0] body_rate_y_i,
  input logic signed [AngW-1:0] body_rate_z_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [ThrW-1:0]        motor_front_right_o,
  input logic [ThrW-1:0]        motor_front_left_o,
  input logic [ThrW-1:0]        motor_rear_left_o,
  input logic [ThrW-1:0]        motor_rear_right_o
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(motor_front_right_o)
      && $stable(motor_front_left_o) && $stable(motor_rear_left_o)
      && $stable(motor_rear_right_o))
    else $error("result beat changed while stalled");

  // Motor commands stay within 0..1
  a_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_front_right_o <= Q12_ONE) && (motor_front_left_o <= Q12_ONE)
      && (motor_rear_left_o <= Q12_ONE) && (motor_rear_right_o <= Q12_ONE))
    else $error("motor command above full scale");

  // One tick at a time: busy right after an input beat
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a tick is in flight");

  // A new result appears only as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while sequencer busy");

endmodule

bind attitude_rate_pid_quad_mixer_core arpqm_checker u_arpqm_checker (.*);
